[rtl/core/rei_pkg.sv]
// Shared types, register indexes and fixed-point helpers for the ray/ellipsoid block.
// Used by every module in rtl/core; depends on nothing.
package rei_pkg;

	localparam int FIX_W = 32;

	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_CENTER_X = 3'd0;
	localparam reg_idx_t REG_CENTER_Y = 3'd1;
	localparam reg_idx_t REG_CENTER_Z = 3'd2;
	localparam reg_idx_t REG_INV_RX   = 3'd3;
	localparam reg_idx_t REG_INV_RY   = 3'd4;
	localparam reg_idx_t REG_INV_RZ   = 3'd5;

	localparam logic [FIX_W-2:0] INV_RADIUS_RESET = 31'd65536;

	// Ray data that rides alongside the square root and divider pipelines.
	typedef struct packed {
		fix_t [2:0] o;
		fix_t [2:0] d;
		fix_t       tmin;
		fix_t       tmax;
		fix_t       a;
		fix_t       b;
		logic       miss;
	} ray_tag_t;

	function automatic logic signed [63:0] ext(input fix_t x);
		return {{32{x[FIX_W-1]}}, x};
	endfunction

	function automatic fix_t sat_fix(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[FIX_W-1:0];
	endfunction

endpackage

[rtl/core/ray_ellipsoid_intersect.sv]
// Top level of the ray / axis-aligned ellipsoid intersection pipeline.
// Depends on rei_pkg, rei_sqrt and rei_div.
//
//  channel   handshake          payload
//  config    wr_en              wr_index, wr_data
//  ray in    start (busy = 0)   origin_x/y/z, dir_x/y/z, t_min, t_max
//  result    done strobe        hit, hit_t, point_x/y/z, normal_x/y/z, front_face
//
// One item is accepted every cycle; busy is always low.
// The pipeline holds a bit-per-stage square root and a bit-per-stage divider.
// arst_n clears all valid bits and the configuration registers to their reset values.
// The result receiver cannot stall, so the pipeline never holds.
module ray_ellipsoid_intersect import rei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  reg_idx_t          wr_index,
	input  logic [FIX_W-1:0]  wr_data,
	input  logic              start,
	output logic              busy,
	input  fix_t              origin_x,
	input  fix_t              origin_y,
	input  fix_t              origin_z,
	input  fix_t              dir_x,
	input  fix_t              dir_y,
	input  fix_t              dir_z,
	input  fix_t              t_min,
	input  fix_t              t_max,
	output logic              done,
	output logic              hit,
	output fix_t              hit_t,
	output fix_t              point_x,
	output fix_t              point_y,
	output fix_t              point_z,
	output fix_t              normal_x,
	output fix_t              normal_y,
	output fix_t              normal_z,
	output logic              front_face
);
	localparam int VW  = FIX_W - 1 + FRAC_BITS;
	localparam int SQW = (VW + 1) / 2;
	localparam int MW  = FIX_W + FRAC_BITS;
	localparam int TW  = $bits(ray_tag_t);
	localparam logic signed [63:0] ONE_FIX = 64'sd1 <<< FRAC_BITS;

	function automatic fix_t fmul(input fix_t p, input fix_t q);
		logic signed [63:0] pr;
		pr = ext(p) * ext(q);
		return sat_fix(pr >>> FRAC_BITS);
	endfunction

	function automatic fix_t sat_quo(input logic [MW-1:0] mag, input logic neg);
		logic signed [MW:0] v;
		v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		return sat_fix({{(63-MW){v[MW]}}, v});
	endfunction

	assign busy = 1'b0;

	// Configuration registers
	fix_t             center_q [3];
	logic [FIX_W-2:0] irad_q   [3];
	fix_t             irsq_q   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				center_q[i] <= '0;
				irad_q[i]   <= INV_RADIUS_RESET;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X: center_q[0] <= wr_data;
				REG_CENTER_Y: center_q[1] <= wr_data;
				REG_CENTER_Z: center_q[2] <= wr_data;
				REG_INV_RX:   irad_q[0]   <= wr_data[FIX_W-2:0];
				REG_INV_RY:   irad_q[1]   <= wr_data[FIX_W-2:0];
				REG_INV_RZ:   irad_q[2]   <= wr_data[FIX_W-2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			irsq_q[i] <= fmul({1'b0, irad_q[i]}, {1'b0, irad_q[i]});
		end
	end

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13;
	logic sq_valid, dv_valid;

	// Stage payloads
	fix_t o_s1 [3], d_s1 [3], diff_s1 [3], tmin_s1, tmax_s1;
	fix_t o_s2 [3], d_s2 [3], n_s2 [3], r_s2 [3], tmin_s2, tmax_s2;
	fix_t o_s3 [3], d_s3 [3], nn_s3 [3], nr_s3 [3], rr_s3 [3], tmin_s3, tmax_s3;
	fix_t o_s4 [3], d_s4 [3], a_s4, b_s4, c_s4, tmin_s4, tmax_s4;
	fix_t o_s5 [3], d_s5 [3], a_s5, b_s5, bb_s5, ac_s5, tmin_s5, tmax_s5;
	fix_t disc_s6;
	ray_tag_t tag_s6, tag_s7, tag_s8, tag_s9;
	logic signed [MW:0] nnear_s7, nfar_s7;
	fix_t tn_s8, tf_s8;
	fix_t t_s9;
	logic hit_s9;
	fix_t o_s10 [3], d_s10 [3], dt_s10 [3], t_s10;
	logic hit_s10;
	fix_t d_s11 [3], p_s11 [3], q_s11 [3], t_s11;
	logic hit_s11;
	fix_t d_s12 [3], p_s12 [3], nm_s12 [3], t_s12;
	logic hit_s12;
	fix_t p_s13 [3], nm_s13 [3], dn_s13 [3], t_s13;
	logic hit_s13;

	logic [SQW-1:0] sq_root;
	logic [TW-1:0]  sq_tag;
	ray_tag_t       sq_ray;
	logic [MW-1:0]  dq_near, dq_far;
	logic           dn_near, dn_far;
	logic [TW-1:0]  dv_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, done} <= '0;
		end else begin
			v_s1  <= start;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= sq_valid;
			v_s8  <= dv_valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			done  <= v_s13;
		end
	end

	// Front end: move into unit-sphere space and form the quadratic.
	always_ff @(posedge clk) begin
		o_s1    <= '{origin_x, origin_y, origin_z};
		d_s1    <= '{dir_x, dir_y, dir_z};
		diff_s1 <= '{sat_fix(ext(origin_x) - ext(center_q[0])),
		             sat_fix(ext(origin_y) - ext(center_q[1])),
		             sat_fix(ext(origin_z) - ext(center_q[2]))};
		tmin_s1 <= t_min;
		tmax_s1 <= t_max;

		for (int i = 0; i < 3; i++) begin
			n_s2[i]  <= fmul(diff_s1[i], {1'b0, irad_q[i]});
			r_s2[i]  <= fmul(d_s1[i], {1'b0, irad_q[i]});
			nn_s3[i] <= fmul(n_s2[i], n_s2[i]);
			nr_s3[i] <= fmul(n_s2[i], r_s2[i]);
			rr_s3[i] <= fmul(r_s2[i], r_s2[i]);
		end
		o_s2 <= o_s1;  d_s2 <= d_s1;  tmin_s2 <= tmin_s1;  tmax_s2 <= tmax_s1;
		o_s3 <= o_s2;  d_s3 <= d_s2;  tmin_s3 <= tmin_s2;  tmax_s3 <= tmax_s2;

		a_s4 <= sat_fix(ext(rr_s3[0]) + ext(rr_s3[1]) + ext(rr_s3[2]));
		b_s4 <= sat_fix(ext(nr_s3[0]) + ext(nr_s3[1]) + ext(nr_s3[2]));
		c_s4 <= sat_fix(ext(nn_s3[0]) + ext(nn_s3[1]) + ext(nn_s3[2]) - ONE_FIX);
		o_s4 <= o_s3;  d_s4 <= d_s3;  tmin_s4 <= tmin_s3;  tmax_s4 <= tmax_s3;

		bb_s5 <= fmul(b_s4, b_s4);
		ac_s5 <= fmul(a_s4, c_s4);
		a_s5  <= a_s4;
		b_s5  <= b_s4;
		o_s5 <= o_s4;  d_s5 <= d_s4;  tmin_s5 <= tmin_s4;  tmax_s5 <= tmax_s4;

		disc_s6 <= sat_fix(ext(bb_s5) - ext(ac_s5));
		tag_s6.o    <= {o_s5[2], o_s5[1], o_s5[0]};
		tag_s6.d    <= {d_s5[2], d_s5[1], d_s5[0]};
		tag_s6.tmin <= tmin_s5;
		tag_s6.tmax <= tmax_s5;
		tag_s6.a    <= a_s5;
		tag_s6.b    <= b_s5;
		tag_s6.miss <= (bb_s5 < ac_s5) || a_s5[FIX_W-1] || (a_s5 == '0) ||
		               sat_fix(ext(bb_s5) - ext(ac_s5)) < 0;
	end

	rei_sqrt #(.VW(VW), .TW(TW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.value     ({disc_s6[FIX_W-2:0], {FRAC_BITS{1'b0}}}),
		.tag_in    (tag_s6),
		.out_valid (sq_valid),
		.root      (sq_root),
		.tag_out   (sq_tag)
	);

	assign sq_ray = ray_tag_t'(sq_tag);

	// Both candidate numerators, scaled by one, go to the divider side by side.
	always_ff @(posedge clk) begin
		logic signed [FIX_W+1:0] nb;
		logic signed [FIX_W+1:0] sqe;
		logic signed [FIX_W+1:0] dnr;
		logic signed [FIX_W+1:0] dfr;
		nb  = -{{2{sq_ray.b[FIX_W-1]}}, sq_ray.b};
		sqe = $signed((FIX_W+2)'(sq_root));
		dnr = nb - sqe;
		dfr = nb + sqe;
		nnear_s7 <= {dnr[FIX_W:0], {FRAC_BITS{1'b0}}};
		nfar_s7  <= {dfr[FIX_W:0], {FRAC_BITS{1'b0}}};
		tag_s7   <= sq_ray;
	end

	rei_div #(.MW(MW), .TW(TW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.num0      (nnear_s7),
		.num1      (nfar_s7),
		.den       (tag_s7.a[FIX_W-2:0]),
		.tag_in    (tag_s7),
		.out_valid (dv_valid),
		.quo0      (dq_near),
		.quo1      (dq_far),
		.neg0      (dn_near),
		.neg1      (dn_far),
		.tag_out   (dv_tag)
	);

	// Back end: pick the root, then the hit point and the facing normal.
	always_ff @(posedge clk) begin
		logic ok_near;
		logic ok_far;
		ok_near = !(tn_s8 < tag_s8.tmin || tn_s8 > tag_s8.tmax);
		ok_far  = !(tf_s8 < tag_s8.tmin || tf_s8 > tag_s8.tmax);

		tn_s8  <= sat_quo(dq_near, dn_near);
		tf_s8  <= sat_quo(dq_far, dn_far);
		tag_s8 <= ray_tag_t'(dv_tag);

		t_s9   <= ok_near ? tn_s8 : tf_s8;
		hit_s9 <= !tag_s8.miss && (ok_near || ok_far);
		tag_s9 <= tag_s8;

		for (int i = 0; i < 3; i++) begin
			o_s10[i]  <= tag_s9.o[i];
			d_s10[i]  <= tag_s9.d[i];
			dt_s10[i] <= fmul(tag_s9.d[i], t_s9);

			p_s11[i]  <= sat_fix(ext(o_s10[i]) + ext(dt_s10[i]));
			q_s11[i]  <= sat_fix(ext(sat_fix(ext(o_s10[i]) + ext(dt_s10[i])))
			                     - ext(center_q[i]));
			d_s11[i]  <= d_s10[i];

			nm_s12[i] <= fmul(q_s11[i], irsq_q[i]);
			p_s12[i]  <= p_s11[i];
			d_s12[i]  <= d_s11[i];

			dn_s13[i] <= fmul(d_s12[i], nm_s12[i]);
			nm_s13[i] <= nm_s12[i];
			p_s13[i]  <= p_s12[i];
		end
		t_s10 <= t_s9;   hit_s10 <= hit_s9;
		t_s11 <= t_s10;  hit_s11 <= hit_s10;
		t_s12 <= t_s11;  hit_s12 <= hit_s11;
		t_s13 <= t_s12;  hit_s13 <= hit_s12;
	end

	// Output register; a miss reports zeros in every field.
	always_ff @(posedge clk) begin
		logic signed [63:0] dot;
		logic               front;
		fix_t               nf [3];
		dot   = ext(dn_s13[0]) + ext(dn_s13[1]) + ext(dn_s13[2]);
		front = dot[63];
		for (int i = 0; i < 3; i++) begin
			nf[i] = front ? nm_s13[i] : sat_fix(-ext(nm_s13[i]));
		end
		hit        <= v_s13 && hit_s13;
		hit_t      <= hit_s13 ? t_s13 : '0;
		point_x    <= hit_s13 ? p_s13[0] : '0;
		point_y    <= hit_s13 ? p_s13[1] : '0;
		point_z    <= hit_s13 ? p_s13[2] : '0;
		normal_x   <= hit_s13 ? nf[0] : '0;
		normal_y   <= hit_s13 ? nf[1] : '0;
		normal_z   <= hit_s13 ? nf[2] : '0;
		front_face <= hit_s13 && front;
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_t == '0 && point_x == '0 && normal_x == '0 && !front_face))
		else $error("miss result carries nonzero fields");

	a_hit_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && hit_s9) |-> !(t_s9 < tag_s9.tmin || t_s9 > tag_s9.tmax))
		else $error("chosen root lies outside the t window");

	a_hit_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit flag raised without a result strobe");

	a_div_follows_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> $past(v_s7, MW + 2))
		else $error("divider produced an item that never entered it");

endmodule

[rtl/core/rei_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with a side tag.
// Depends on rei_pkg.
module rei_sqrt import rei_pkg::*; #(
	parameter int VW = 47,
	parameter int TW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [VW-1:0]         value,
	input  logic [TW-1:0]         tag_in,
	output logic                  out_valid,
	output logic [(VW+1)/2-1:0]   root,
	output logic [TW-1:0]         tag_out
);
	localparam int NP  = (VW + 1) / 2;
	localparam int PW  = 2 * NP;
	localparam int RMW = NP + 2;

	logic [PW-1:0]  work_s [NP+1];
	logic [RMW-1:0] rem_s  [NP+1];
	logic [NP-1:0]  root_s [NP+1];
	logic [TW-1:0]  tag_s  [NP+1];
	logic           vld_s  [NP+1];

	assign work_s[0] = PW'(value);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_in;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < NP; k++) begin : g_stage
		logic [RMW+1:0] pre;
		logic [RMW+1:0] trial;
		logic           ge;

		always_comb begin
			pre   = {rem_s[k], work_s[k][PW-1:PW-2]};
			trial = (RMW+2)'({root_s[k], 2'b01});
			ge    = (pre >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			work_s[k+1] <= {work_s[k][PW-3:0], 2'b00};
			rem_s[k+1]  <= ge ? RMW'(pre - trial) : RMW'(pre);
			root_s[k+1] <= {root_s[k][NP-2:0], ge};
			tag_s[k+1]  <= tag_s[k];
		end
	end

	assign out_valid = vld_s[NP];
	assign root      = root_s[NP];
	assign tag_out   = tag_s[NP];

endmodule

[rtl/core/rei_div.sv]
// Pipelined two-lane restoring divider sharing one positive divisor, one quotient
// bit per stage; returns magnitude and sign. Depends on rei_pkg.
module rei_div import rei_pkg::*; #(
	parameter int MW = 48,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [MW:0]   num0,
	input  logic signed [MW:0]   num1,
	input  logic [FIX_W-2:0]     den,
	input  logic [TW-1:0]        tag_in,
	output logic                 out_valid,
	output logic [MW-1:0]        quo0,
	output logic [MW-1:0]        quo1,
	output logic                 neg0,
	output logic                 neg1,
	output logic [TW-1:0]        tag_out
);
	localparam int RW = FIX_W;

	logic [MW-1:0]    w0_s [MW+1];
	logic [MW-1:0]    w1_s [MW+1];
	logic [RW-1:0]    r0_s [MW+1];
	logic [RW-1:0]    r1_s [MW+1];
	logic             n0_s [MW+1];
	logic             n1_s [MW+1];
	logic [FIX_W-2:0] d_s  [MW+1];
	logic [TW-1:0]    tag_s [MW+1];
	logic             vld_s [MW+1];

	logic signed [MW:0] abs0;
	logic signed [MW:0] abs1;

	always_comb begin
		abs0 = num0[MW] ? -num0 : num0;
		abs1 = num1[MW] ? -num1 : num1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		w0_s[0]  <= abs0[MW-1:0];
		w1_s[0]  <= abs1[MW-1:0];
		r0_s[0]  <= '0;
		r1_s[0]  <= '0;
		n0_s[0]  <= num0[MW];
		n1_s[0]  <= num1[MW];
		d_s[0]   <= den;
		tag_s[0] <= tag_in;
	end

	for (genvar k = 0; k < MW; k++) begin : g_stage
		logic [RW-1:0] pre0;
		logic [RW-1:0] pre1;
		logic [RW-1:0] dv;
		logic          ge0;
		logic          ge1;

		always_comb begin
			pre0 = {r0_s[k][RW-2:0], w0_s[k][MW-1]};
			pre1 = {r1_s[k][RW-2:0], w1_s[k][MW-1]};
			dv   = {1'b0, d_s[k]};
			ge0  = (pre0 >= dv);
			ge1  = (pre1 >= dv);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			r0_s[k+1]  <= ge0 ? pre0 - dv : pre0;
			r1_s[k+1]  <= ge1 ? pre1 - dv : pre1;
			w0_s[k+1]  <= {w0_s[k][MW-2:0], ge0};
			w1_s[k+1]  <= {w1_s[k][MW-2:0], ge1};
			n0_s[k+1]  <= n0_s[k];
			n1_s[k+1]  <= n1_s[k];
			d_s[k+1]   <= d_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[MW];
	assign quo0      = w0_s[MW];
	assign quo1      = w1_s[MW];
	assign neg0      = n0_s[MW];
	assign neg1      = n1_s[MW];
	assign tag_out   = tag_s[MW];

endmodule

[verif/ray_ellipsoid_intersect_test.sv]
// Self-checking testbench for ray_ellipsoid_intersect: drives rays, predicts each result
// in fixed point and compares the outputs field by field. Depends on rei_pkg and the RTL.
module ray_ellipsoid_intersect_test import rei_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint S_MAX = 64'sd2147483647;
	localparam longint S_MIN = -64'sd2147483648;
	localparam longint ONE_Q = 64'sd65536;
	localparam int LATENCY = 87;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		fix_t o[3];
		fix_t d[3];
		fix_t tmin;
		fix_t tmax;
	} ray_t;

	typedef struct {
		logic hit;
		fix_t t;
		fix_t p[3];
		fix_t n[3];
		logic ff;
	} hit_rec_t;

	logic clk = 0, arst_n = 0;
	logic wr_en = 0;
	reg_idx_t wr_index = REG_CENTER_X;
	logic [FIX_W-1:0] wr_data = '0;
	logic start = 0;
	logic busy, done, hit, front_face;
	fix_t origin_x = 0, origin_y = 0, origin_z = 0;
	fix_t dir_x = 0, dir_y = 0, dir_z = 0, t_min = 0, t_max = 0;
	fix_t hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z;

	longint ctr[3];
	longint inv_r[3];
	hit_rec_t pending_hits[$];
	int errors = 0;
	int idle_cycles = 0;

	ray_ellipsoid_intersect uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint sat(longint x);
		if (x > S_MAX) return S_MAX;
		if (x < S_MIN) return S_MIN;
		return x;
	endfunction

	// Arithmetic shift floors toward minus infinity.
	function automatic longint qmul(longint p, longint q);
		return sat((p * q) >>> FRAC);
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic hit_rec_t predict_hit(ray_t r);
		hit_rec_t e;
		longint o[3], d[3], n[3], s[3], p[3], nm[3];
		longint a, b, c, disc, sq, t, dot;
		bit ok;
		e.hit = 0; e.t = 0; e.ff = 0;
		for (int i = 0; i < 3; i++) begin
			e.p[i] = 0; e.n[i] = 0;
			o[i] = r.o[i]; d[i] = r.d[i];
			n[i] = qmul(sat(o[i] - ctr[i]), inv_r[i]);
			s[i] = qmul(d[i], inv_r[i]);
		end
		a = sat(qmul(s[0], s[0]) + qmul(s[1], s[1]) + qmul(s[2], s[2]));
		b = sat(qmul(n[0], s[0]) + qmul(n[1], s[1]) + qmul(n[2], s[2]));
		c = sat(qmul(n[0], n[0]) + qmul(n[1], n[1]) + qmul(n[2], n[2]) - ONE_Q);
		disc = sat(qmul(b, b) - qmul(a, c));
		if (disc < 0 || a <= 0) return e;
		sq = isqrt(longint'(disc) << FRAC);
		t = sat(((-b - sq) * ONE_Q) / a);
		ok = !(t < r.tmin || t > r.tmax);
		if (!ok) begin
			t = sat(((-b + sq) * ONE_Q) / a);
			ok = !(t < r.tmin || t > r.tmax);
		end
		if (!ok) return e;
		for (int i = 0; i < 3; i++) begin
			p[i] = sat(o[i] + qmul(d[i], t));
			nm[i] = qmul(sat(p[i] - ctr[i]), qmul(inv_r[i], inv_r[i]));
		end
		dot = qmul(d[0], nm[0]) + qmul(d[1], nm[1]) + qmul(d[2], nm[2]);
		for (int i = 0; i < 3; i++) begin
			if (dot >= 0) nm[i] = sat(-nm[i]);
			e.p[i] = p[i];
			e.n[i] = nm[i];
		end
		e.hit = 1;
		e.t = t;
		e.ff = dot < 0;
		return e;
	endfunction

	// Called at a falling edge; returns at the falling edge that follows the one where the enable drops.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		wr_en <= 1; wr_index <= idx; wr_data <= val;
		@(negedge clk);
		wr_en <= 0;
		@(negedge clk);
		// An index outside the register set is ignored by the block.
		case (idx)
			REG_CENTER_X: ctr[0] = longint'(fix_t'(val));
			REG_CENTER_Y: ctr[1] = longint'(fix_t'(val));
			REG_CENTER_Z: ctr[2] = longint'(fix_t'(val));
			REG_INV_RX:   inv_r[0] = val[30:0];
			REG_INV_RY:   inv_r[1] = val[30:0];
			REG_INV_RZ:   inv_r[2] = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_shape(fix_t cx, fix_t cy, fix_t cz, int rx, int ry, int rz);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_INV_RX, rx);
		write_reg(REG_INV_RY, ry);
		write_reg(REG_INV_RZ, rz);
	endtask

	// Called at a falling edge; leaves start high so back-to-back items stay continuous.
	task automatic send_ray(ray_t r, bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
		dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
		t_min <= r.tmin; t_max <= r.tmax;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_hits.push_back(predict_hit(r));
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	function automatic fix_t q(int whole);
		return fix_t'(whole * 65536);
	endfunction

	function automatic ray_t mk(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy, fix_t dz,
			fix_t lo, fix_t hi);
		ray_t r;
		r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
		r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
		r.tmin = lo; r.tmax = hi;
		return r;
	endfunction

	// Mostly rays aimed near the ellipsoid so that hits are common, some pure noise.
	function automatic ray_t random_ray;
		ray_t r;
		int k = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			if (k == 0) begin
				r.o[i] = $urandom; r.d[i] = $urandom;
			end else begin
				r.o[i] = fix_t'(ctr[i]) + $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
				r.d[i] = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
			end
		end
		if (k == 0) begin
			r.tmin = $urandom; r.tmax = $urandom;
		end else begin
			r.tmin = $signed($urandom_range(0, 2 * 65536)) - 65536;
			r.tmax = (k == 1) ? r.tmin - 1 : r.tmin + $signed($urandom_range(0, 40 * 65536));
		end
		return r;
	endfunction

	task automatic test_directed;
		send_ray(mk(q(-5), 0, 0, q(1), 0, 0, 0, q(100)), 0);       // outside, front hit
		send_ray(mk(0, 0, 0, q(1), 0, 0, 0, q(100)), 0);           // inside, back face
		send_ray(mk(q(-5), q(3), 0, q(1), 0, 0, 0, q(100)), 0);     // clean miss
		send_ray(mk(q(-5), 0, 0, 0, 0, 0, 0, q(100)), 0);           // zero direction
		send_ray(mk(q(-5), 0, 0, q(1), 0, 0, q(10), q(1)), 0);      // empty window
		send_ray(mk(q(-5), 0, 0, q(1), 0, 0, q(5), q(7)), 0);       // far root only
		send_ray(mk(q(5), 0, 0, q(-1), 0, 0, 0, q(1)), 0);          // roots outside window
		send_ray(mk(0, q(-5), 0, 0, q(2), 0, 0, q(100)), 0);
		send_ray(mk(0, 0, q(-5), 0, 0, q(1), 0, q(100)), 0);
		send_ray(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff), 0);
		send_ray(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff), 0);
		send_ray(mk(q(-5), 0, 0, 1, 0, 0, 32'sh80000000, 32'sh7fffffff), 0);
		send_ray(mk(q(-1), 0, 0, q(1), 0, 0, 0, 0), 0);             // tangent to window edge
		send_ray(mk(q(-5), q(1), 0, q(1), 0, 0, 0, q(100)), 0);     // grazing
		drain();
	endtask

	task automatic test_shapes;
		set_shape(q(2), q(-3), q(1), 32768, 131072, 65536);
		for (int i = 0; i < 200; i++) send_ray(random_ray(), 1);
		drain();
		set_shape(32'sh7fffffff, 32'sh80000000, 0, 31'h7fffffff, 0, 1);
		send_ray(mk(0, 0, 0, q(1), q(1), q(1), 32'sh80000000, 32'sh7fffffff), 0);
		for (int i = 0; i < 50; i++) send_ray(random_ray(), 1);
		drain();
		set_shape(0, 0, 0, 0, 0, 0);
		write_reg(reg_idx_t'(6), 32'hdeadbeef);
		write_reg(reg_idx_t'(7), 32'h12345678);
		send_ray(mk(q(-5), 0, 0, q(1), 0, 0, 0, q(100)), 0);
		drain();
	endtask

	task automatic test_random;
		for (int s = 0; s < 4; s++) begin
			set_shape($signed($urandom_range(0, 8 * 65536)) - 4 * 65536,
				$signed($urandom_range(0, 8 * 65536)) - 4 * 65536,
				$signed($urandom_range(0, 8 * 65536)) - 4 * 65536,
				$urandom_range(8192, 262144), $urandom_range(8192, 262144),
				$urandom_range(8192, 262144));
			for (int i = 0; i < 180; i++) send_ray(random_ray(), 1);
			drain();
		end
	endtask

	// Results arrive one per strobe and cannot be held off.
	always @(posedge clk) begin
		hit_rec_t e;
		if (done && arst_n) begin
			if (pending_hits.size() == 0) begin
				$display("%t unexpected result: expected none, actual hit=%b t=%h",
					$realtime, hit, hit_t);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if ({hit, hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z,
						front_face} !== {e.hit, e.t, e.p[0], e.p[1], e.p[2], e.n[0],
						e.n[1], e.n[2], e.ff}) begin
					$display("%t mismatch: expected hit=%b t=%h p=%h %h %h n=%h %h %h ff=%b",
						$realtime, e.hit, e.t, e.p[0], e.p[1], e.p[2], e.n[0], e.n[1],
						e.n[2], e.ff);
					$display("%t            actual hit=%b t=%h p=%h %h %h n=%h %h %h ff=%b",
						$realtime, hit, hit_t, point_x, point_y, point_z, normal_x,
						normal_y, normal_z, front_face);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		ctr = '{0, 0, 0};
		inv_r = '{65536, 65536, 65536};
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_shapes();
		test_random();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
